[sv/mhku_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mhku_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxW = 7;
  localparam int unsigned MaxDepth = 128;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_DECREASE = 2'd1,
    CMD_INCREASE = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_WRONG_DIR = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                   command;
    logic [IdxW-1:0]        index;
    logic signed [KeyW-1:0] new_key;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] min_key;
    logic [IdxW-1:0]        entry_count;
    logic [IdxW-1:0]        final_index;
    logic signed [KeyW-1:0] read_key;
  } out_t;

endpackage

`default_nettype wire

[sv/mhku_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhku_ram import mhku_pkg::*; #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic signed [KeyW-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic signed [KeyW-1:0] rdata_o
);

  logic signed [KeyW-1:0] mem [Depth];
  logic signed [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/min_heap_key_update_unit.sv]
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy accepts     item_i   (in_t)
// result    out        done_o, one cycle, no hold result_o (out_t)
//
// Append, bad index and heap full go from idle straight to the finish state, read
// via the RAM read state S_RD. Decrease-key compares with one parent per step, plus
// a write state when the key reaches the root; increase-key per child level reads
// left, then any right child on the one read port, then compares; a leaf adds a write.
// Async active-low reset clears the count and the sequencer, not the key RAM.
// The receiver cannot stall; busy is low while a result shows.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_key_update_unit import mhku_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned Depth = (CAPACITY < MaxDepth) ? CAPACITY : MaxDepth;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [IdxW-1:0] MaxEntries = IdxW'(Depth - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_UP   = 4'd3;
  localparam logic [3:0] S_PUT  = 4'd4;
  localparam logic [3:0] S_DNL  = 4'd5;
  localparam logic [3:0] S_DNR  = 4'd6;
  localparam logic [3:0] S_DNC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]             state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  status_e                status_q, status_d;
  logic [IdxW-1:0]        pos_q, pos_d;
  logic [IdxW-1:0]        count_q, count_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] pick_q, pick_d;
  logic                   right_q, right_d;
  logic signed [KeyW-1:0] rkey_q, rkey_d;
  logic signed [KeyW-1:0] root_q;
  logic                   done_q;
  out_t                   res_q;

  logic                   ram_we, ram_re;
  logic [IdxW-1:0]        wpos, rpos;
  logic signed [KeyW-1:0] ram_wdata, ram_rdata;

  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic                   cmp_lt;

  logic [IdxW:0]   child, child_r, count_x, nxt_child;
  logic [IdxW-1:0] nxt_pos;
  logic            bad_idx;

  mhku_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rpos[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared signed comparator
  assign cmp_lt = cmp_a < cmp_b;

  assign child     = {pos_q, 1'b0};
  assign child_r   = {pos_q, 1'b1};
  assign count_x   = {1'b0, count_q};
  assign nxt_pos   = right_q ? child_r[IdxW-1:0] : child[IdxW-1:0];
  assign nxt_child = {nxt_pos, 1'b0};
  assign bad_idx   = (item_i.index == '0) || (item_i.index > count_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    status_d  = status_q;
    pos_d     = pos_q;
    count_d   = count_q;
    key_d     = key_q;
    pick_d    = pick_q;
    right_d   = right_q;
    rkey_d    = rkey_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    wpos      = pos_q;
    rpos      = pos_q;
    ram_wdata = key_q;
    cmp_a     = key_q;
    cmp_b     = ram_rdata;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = item_i.command;
          key_d    = item_i.new_key;
          rkey_d   = '0;
          status_d = ST_OK;
          state_d  = S_FIN;
          if (item_i.command == CMD_APPEND) begin
            if (count_q >= MaxEntries) begin
              status_d = ST_FULL;
              pos_d    = '0;
            end else begin
              ram_we    = 1'b1;
              wpos      = count_q + 1'b1;
              ram_wdata = item_i.new_key;
              count_d   = count_q + 1'b1;
              pos_d     = count_q + 1'b1;
            end
          end else if (bad_idx) begin
            status_d = ST_BAD_INDEX;
            pos_d    = '0;
          end else begin
            ram_re  = 1'b1;
            rpos    = item_i.index;
            pos_d   = item_i.index;
            state_d = (item_i.command == CMD_READ) ? S_RD : S_CHK;
          end
        end
      end
      S_RD: begin
        rkey_d  = ram_rdata;
        state_d = S_FIN;
      end
      S_CHK: begin
        if (cmd_q == CMD_DECREASE) begin
          cmp_a = key_q;
          cmp_b = ram_rdata;
        end else begin
          cmp_a = ram_rdata;
          cmp_b = key_q;
        end
        status_d = cmp_lt ? ST_OK : ST_WRONG_DIR;
        if (cmd_q == CMD_DECREASE && pos_q > 1) begin
          ram_re  = 1'b1;
          rpos    = pos_q >> 1;
          state_d = S_UP;
        end else if (cmd_q == CMD_INCREASE && child <= count_x) begin
          ram_re  = 1'b1;
          rpos    = child[IdxW-1:0];
          state_d = S_DNL;
        end else begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_UP: begin
        cmp_a = key_q;
        cmp_b = ram_rdata;
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = pos_q >> 1;
          if ((pos_q >> 1) > 1) begin
            ram_re = 1'b1;
            rpos   = pos_q >> 2;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_PUT: begin
        ram_we  = 1'b1;
        state_d = S_FIN;
      end
      S_DNL: begin
        pick_d  = ram_rdata;
        right_d = 1'b0;
        if (child_r <= count_x) begin
          ram_re  = 1'b1;
          rpos    = child_r[IdxW-1:0];
          state_d = S_DNR;
        end else begin
          state_d = S_DNC;
        end
      end
      S_DNR: begin
        cmp_a = ram_rdata;
        cmp_b = pick_q;
        if (cmp_lt) begin
          pick_d  = ram_rdata;
          right_d = 1'b1;
        end
        state_d = S_DNC;
      end
      S_DNC: begin
        cmp_a = pick_q;
        cmp_b = key_q;
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_wdata = pick_q;
          pos_d     = nxt_pos;
          if (nxt_child <= count_x) begin
            ram_re  = 1'b1;
            rpos    = nxt_child[IdxW-1:0];
            state_d = S_DNL;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == S_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    pick_q   <= pick_d;
    right_q  <= right_d;
    rkey_q   <= rkey_d;
    if (ram_we && wpos == IdxW'(1)) begin
      root_q <= ram_wdata;
    end
    if (state_q == S_FIN) begin
      res_q.status      <= status_q;
      res_q.min_key     <= (count_q != '0) ? root_q : '0;
      res_q.entry_count <= count_q;
      res_q.final_index <= pos_q;
      res_q.read_key    <= rkey_q;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxEntries)
    else $error("entry count above capacity");
  a_reject_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == ST_BAD_INDEX || result_o.status == ST_FULL)
      |-> result_o.final_index == '0)
    else $error("rejected item reports a position");
`endif

endmodule

`default_nettype wire
